### hdl/quaternion_to_rotation_matrix_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to rotation matrix block
// Both macros expect clk and rst_n to be visible where they are used.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QRM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qrm: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define QRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qrm: next-cycle check failed");

`endif

### hdl/qrm_pkg.sv
// ----------------------------------------------------------------------------
// qrm_pkg
// Types, constants and helper functions for the quaternion to rotation
// matrix pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

  localparam int COMP_W    = 32;
  localparam int ENT_W     = 32;
  localparam int NUM_COMP  = 4;
  localparam int NUM_CROSS = 6;
  localparam int NUM_DIAG  = 3;
  localparam int NUM_OFF   = 6;
  localparam int NUM_ENT   = 9;
  localparam int SQ_W      = 62;
  localparam int CROSS_W   = 63;
  localparam int PAIR_W    = 63;
  localparam int NORM_W    = 64;
  localparam int QUO_W     = 31;
  localparam int DIV_STEPS = QUO_W;

  typedef logic signed [COMP_W-1:0]  comp_t;
  typedef logic signed [ENT_W-1:0]   ent_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic [PAIR_W-1:0]         pair_t;
  typedef logic signed [NORM_W-1:0]  off_t;
  typedef logic [NORM_W-1:0]         norm_t;
  typedef logic [NORM_W:0]           part_t;
  typedef logic [QUO_W-1:0]          quo_t;
  typedef logic [NUM_ENT-1:0]        ent_mask_t;
  typedef logic [1:0]                comp_idx_t;
  typedef logic [3:0]                ent_idx_t;

  localparam comp_t COMP_MIN     = 32'sh8000_0000;
  localparam comp_t COMP_MIN_SAT = 32'sh8000_0001;
  localparam quo_t  QUO_ONE      = 31'h4000_0000;
  localparam ent_t  ENT_ONE      = 32'sh4000_0000;
  localparam ent_t  ENT_NEG_ONE  = 32'shC000_0000;

  localparam comp_idx_t IDX_S = 2'd0;
  localparam comp_idx_t IDX_X = 2'd1;
  localparam comp_idx_t IDX_Y = 2'd2;
  localparam comp_idx_t IDX_Z = 2'd3;

  // Cross products in the order xy, xz, yz, sx, sy, sz.
  localparam int CR_XY = 0;
  localparam int CR_XZ = 1;
  localparam int CR_YZ = 2;
  localparam int CR_SX = 3;
  localparam int CR_SY = 4;
  localparam int CR_SZ = 5;
  localparam comp_idx_t CROSS_A [NUM_CROSS] = '{IDX_X, IDX_X, IDX_Y, IDX_S, IDX_S, IDX_S};
  localparam comp_idx_t CROSS_B [NUM_CROSS] = '{IDX_Y, IDX_Z, IDX_Z, IDX_X, IDX_Y, IDX_Z};

  // Matrix entries are numbered row-major from r11.
  localparam ent_idx_t DIAG_ENT [NUM_DIAG] = '{4'd0, 4'd4, 4'd8};
  localparam ent_idx_t OFF_ENT  [NUM_OFF]  = '{4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7};

  // The most negative code is pulled in by one so that the range is symmetric.
  function automatic comp_t clamp_comp(input comp_t c);
    return (c == COMP_MIN) ? COMP_MIN_SAT : c;
  endfunction

  // One restoring division step: returns the quotient bit on top of the
  // new remainder.
  function automatic part_t div_step(input part_t part, input norm_t n);
    part_t nx;
    nx = {1'b0, n};
    if (part >= nx) begin
      return {1'b1, NORM_W'(part - nx)};
    end
    return {1'b0, part[NORM_W-1:0]};
  endfunction

  // Saturates the magnitude to one, applies the sign and zeroes a
  // degenerate result.
  function automatic ent_t finish_ent(input quo_t q, input logic neg, input logic deg);
    quo_t mag;
    ent_t val;
    mag = (q > QUO_ONE) ? QUO_ONE : q;
    val = {1'b0, mag};
    if (deg) begin
      return '0;
    end
    return neg ? -val : val;
  endfunction

endpackage

### hdl/quaternion_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Pipelined conversion of a Q3.28 quaternion to a normalised Q1.30 rotation
// matrix, with a 31-stage restoring divider for each of the nine entries.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the in_ channel carries one scalar-first quaternion; the
//   out_ channel returns the nine matrix entries, row-major, and a flag that
//   marks a zero quaternion (all entries then read zero).
//   Both channels use valid and stall; a request moves on a rising edge at
//   which valid is high and stall is low.
//   An accepted request passes through one input stage, one multiplier
//   stage, two adder stages, 31 divider stages (one quotient bit per stage)
//   and one saturation and sign stage.
//   The block takes one request in every cycle while the receiver keeps up.
//   When the receiver stalls, the pending result moves into a skid register
//   and one more request may still be taken; in_stall then rises and the
//   whole pipeline holds until the skid register has been emptied.
//   Reset clears every valid bit and the skid register; nothing is lost or
//   repeated under any pattern of stalls.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  qrm_pkg::comp_t in_q_scalar,
  input  qrm_pkg::comp_t in_q_x,
  input  qrm_pkg::comp_t in_q_y,
  input  qrm_pkg::comp_t in_q_z,
  output logic           out_valid,
  input  logic           out_stall,
  output qrm_pkg::ent_t  out_r11,
  output qrm_pkg::ent_t  out_r12,
  output qrm_pkg::ent_t  out_r13,
  output qrm_pkg::ent_t  out_r21,
  output qrm_pkg::ent_t  out_r22,
  output qrm_pkg::ent_t  out_r23,
  output qrm_pkg::ent_t  out_r31,
  output qrm_pkg::ent_t  out_r32,
  output qrm_pkg::ent_t  out_r33,
  output logic           out_degenerate
);
  import qrm_pkg::*;

  localparam int LAST = DIV_STEPS - 1;

  logic run;
  logic capture;

  // Input stage
  comp_t a_comp_r   [NUM_COMP];
  comp_t a_comp_nxt [NUM_COMP];
  logic  a_deg_r, a_deg_nxt;
  logic  a_valid_r;

  // Multiplier stage
  sq_t    b_sq_r     [NUM_COMP];
  sq_t    b_sq_nxt   [NUM_COMP];
  cross_t b_cr_r     [NUM_CROSS];
  cross_t b_cr_nxt   [NUM_CROSS];
  logic   b_deg_r;
  logic   b_valid_r;

  // Pair sums and off-diagonal numerators
  pair_t c_pos_r   [NUM_DIAG];
  pair_t c_pos_nxt [NUM_DIAG];
  pair_t c_neg_r   [NUM_DIAG];
  pair_t c_neg_nxt [NUM_DIAG];
  off_t  c_off_r   [NUM_OFF];
  off_t  c_off_nxt [NUM_OFF];
  logic  c_deg_r;
  logic  c_valid_r;

  // Norm, magnitudes and signs
  norm_t     d_num_r   [NUM_ENT];
  norm_t     d_num_nxt [NUM_ENT];
  ent_mask_t d_sign_r, d_sign_nxt;
  norm_t     d_n_r, d_n_nxt;
  logic      d_deg_r;
  logic      d_valid_r;

  // Divider stages
  norm_t     v_rem_r    [DIV_STEPS][NUM_ENT];
  norm_t     v_rem_nxt  [DIV_STEPS][NUM_ENT];
  quo_t      v_quo_r    [DIV_STEPS][NUM_ENT];
  quo_t      v_quo_nxt  [DIV_STEPS][NUM_ENT];
  norm_t     v_n_r      [DIV_STEPS];
  ent_mask_t v_sign_r   [DIV_STEPS];
  logic      v_deg_r    [DIV_STEPS];
  logic [DIV_STEPS-1:0] v_valid_r;

  // Final stage and skid register
  ent_t f_ent_r   [NUM_ENT];
  ent_t f_ent_nxt [NUM_ENT];
  logic f_deg_r;
  logic f_valid_r;
  ent_t sk_ent_r  [NUM_ENT];
  logic sk_deg_r;
  logic sk_full_r, sk_full_nxt;
  ent_t out_ent   [NUM_ENT];
  logic out_all_zero;
  logic out_in_range;

  // The pipeline only holds while the skid register is occupied.
  assign run         = !sk_full_r;
  assign in_stall    = sk_full_r;
  assign capture     = run && f_valid_r && out_stall;
  assign sk_full_nxt = sk_full_r ? out_stall : capture;

  always_comb begin
    a_comp_nxt[IDX_S] = clamp_comp(in_q_scalar);
    a_comp_nxt[IDX_X] = clamp_comp(in_q_x);
    a_comp_nxt[IDX_Y] = clamp_comp(in_q_y);
    a_comp_nxt[IDX_Z] = clamp_comp(in_q_z);
    a_deg_nxt = (in_q_scalar == '0) && (in_q_x == '0) && (in_q_y == '0) && (in_q_z == '0);
  end

  always_comb begin
    off_t prod;
    for (int i = 0; i < NUM_COMP; i++) begin
      prod = NORM_W'(a_comp_r[i]) * NORM_W'(a_comp_r[i]);
      b_sq_nxt[i] = prod[SQ_W-1:0];
    end
    for (int i = 0; i < NUM_CROSS; i++) begin
      prod = NORM_W'(a_comp_r[CROSS_A[i]]) * NORM_W'(a_comp_r[CROSS_B[i]]);
      b_cr_nxt[i] = prod[CROSS_W-1:0];
    end
  end

  always_comb begin
    c_pos_nxt[0] = PAIR_W'(b_sq_r[IDX_S]) + PAIR_W'(b_sq_r[IDX_X]);
    c_neg_nxt[0] = PAIR_W'(b_sq_r[IDX_Y]) + PAIR_W'(b_sq_r[IDX_Z]);
    c_pos_nxt[1] = PAIR_W'(b_sq_r[IDX_S]) + PAIR_W'(b_sq_r[IDX_Y]);
    c_neg_nxt[1] = PAIR_W'(b_sq_r[IDX_X]) + PAIR_W'(b_sq_r[IDX_Z]);
    c_pos_nxt[2] = PAIR_W'(b_sq_r[IDX_S]) + PAIR_W'(b_sq_r[IDX_Z]);
    c_neg_nxt[2] = PAIR_W'(b_sq_r[IDX_X]) + PAIR_W'(b_sq_r[IDX_Y]);
    c_off_nxt[0] = NORM_W'(b_cr_r[CR_XY]) - NORM_W'(b_cr_r[CR_SZ]);
    c_off_nxt[1] = NORM_W'(b_cr_r[CR_XZ]) + NORM_W'(b_cr_r[CR_SY]);
    c_off_nxt[2] = NORM_W'(b_cr_r[CR_XY]) + NORM_W'(b_cr_r[CR_SZ]);
    c_off_nxt[3] = NORM_W'(b_cr_r[CR_YZ]) - NORM_W'(b_cr_r[CR_SX]);
    c_off_nxt[4] = NORM_W'(b_cr_r[CR_XZ]) - NORM_W'(b_cr_r[CR_SY]);
    c_off_nxt[5] = NORM_W'(b_cr_r[CR_YZ]) + NORM_W'(b_cr_r[CR_SX]);
  end

  // Each numerator is at most the norm, so a single quotient bit lies above
  // the binary point and thirty below it.
  always_comb begin
    pair_t up;
    pair_t down;
    off_t  mag;
    d_n_nxt    = NORM_W'(c_pos_r[0]) + NORM_W'(c_neg_r[0]);
    d_sign_nxt = '0;
    for (int i = 0; i < NUM_DIAG; i++) begin
      up   = c_pos_r[i] - c_neg_r[i];
      down = c_neg_r[i] - c_pos_r[i];
      d_sign_nxt[DIAG_ENT[i]] = c_pos_r[i] < c_neg_r[i];
      d_num_nxt[DIAG_ENT[i]]  = NORM_W'((c_pos_r[i] < c_neg_r[i]) ? down : up);
    end
    for (int i = 0; i < NUM_OFF; i++) begin
      mag = c_off_r[i][NORM_W-1] ? -c_off_r[i] : c_off_r[i];
      d_sign_nxt[OFF_ENT[i]] = c_off_r[i][NORM_W-1];
      d_num_nxt[OFF_ENT[i]]  = {mag[NORM_W-2:0], 1'b0};
    end
  end

  always_comb begin
    part_t step;
    for (int e = 0; e < NUM_ENT; e++) begin
      step = div_step({1'b0, d_num_r[e]}, d_n_r);
      v_rem_nxt[0][e] = step[NORM_W-1:0];
      v_quo_nxt[0][e] = {{(QUO_W-1){1'b0}}, step[NORM_W]};
    end
    for (int k = 1; k < DIV_STEPS; k++) begin
      for (int e = 0; e < NUM_ENT; e++) begin
        step = div_step({v_rem_r[k-1][e], 1'b0}, v_n_r[k-1]);
        v_rem_nxt[k][e] = step[NORM_W-1:0];
        v_quo_nxt[k][e] = {v_quo_r[k-1][e][QUO_W-2:0], step[NORM_W]};
      end
    end
  end

  always_comb begin
    for (int e = 0; e < NUM_ENT; e++) begin
      f_ent_nxt[e] = finish_ent(v_quo_r[LAST][e], v_sign_r[LAST][e], v_deg_r[LAST]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      v_valid_r <= '0;
      f_valid_r <= 1'b0;
    end else if (run) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
      v_valid_r <= {v_valid_r[DIV_STEPS-2:0], d_valid_r};
      f_valid_r <= v_valid_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      a_comp_r <= a_comp_nxt;
      a_deg_r  <= a_deg_nxt;
      b_sq_r   <= b_sq_nxt;
      b_cr_r   <= b_cr_nxt;
      b_deg_r  <= a_deg_r;
      c_pos_r  <= c_pos_nxt;
      c_neg_r  <= c_neg_nxt;
      c_off_r  <= c_off_nxt;
      c_deg_r  <= b_deg_r;
      d_num_r  <= d_num_nxt;
      d_sign_r <= d_sign_nxt;
      d_n_r    <= d_n_nxt;
      d_deg_r  <= c_deg_r;
      v_rem_r  <= v_rem_nxt;
      v_quo_r  <= v_quo_nxt;
      v_n_r[0]    <= d_n_r;
      v_sign_r[0] <= d_sign_r;
      v_deg_r[0]  <= d_deg_r;
      for (int k = 1; k < DIV_STEPS; k++) begin
        v_n_r[k]    <= v_n_r[k-1];
        v_sign_r[k] <= v_sign_r[k-1];
        v_deg_r[k]  <= v_deg_r[k-1];
      end
      f_ent_r <= f_ent_nxt;
      f_deg_r <= v_deg_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_full_r <= 1'b0;
    end else begin
      sk_full_r <= sk_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      sk_ent_r <= f_ent_r;
      sk_deg_r <= f_deg_r;
    end
  end

  always_comb begin
    for (int e = 0; e < NUM_ENT; e++) begin
      out_ent[e] = sk_full_r ? sk_ent_r[e] : f_ent_r[e];
    end
  end

  assign out_valid      = sk_full_r || f_valid_r;
  assign out_degenerate = sk_full_r ? sk_deg_r : f_deg_r;
  assign out_r11        = out_ent[0];
  assign out_r12        = out_ent[1];
  assign out_r13        = out_ent[2];
  assign out_r21        = out_ent[3];
  assign out_r22        = out_ent[4];
  assign out_r23        = out_ent[5];
  assign out_r31        = out_ent[6];
  assign out_r32        = out_ent[7];
  assign out_r33        = out_ent[8];

  always_comb begin
    out_all_zero = 1'b1;
    out_in_range = 1'b1;
    for (int e = 0; e < NUM_ENT; e++) begin
      if (out_ent[e] != '0) begin
        out_all_zero = 1'b0;
      end
      if ((out_ent[e] > ENT_ONE) || (out_ent[e] < ENT_NEG_ONE)) begin
        out_in_range = 1'b0;
      end
    end
  end

`include "quaternion_to_rotation_matrix_assert.svh"

  `QRM_ASSERT_NOW(a_degenerate_zero, out_valid && out_degenerate, out_all_zero)
  `QRM_ASSERT_NOW(a_entry_range, out_valid, out_in_range)
  `QRM_ASSERT_NEXT(a_skid_drains, sk_full_r && !out_stall, !sk_full_r)

endmodule
